// ===== rtl/hwq_pkg.sv =====
// ---------------------------------------------------------------------------
// hwq_pkg
// Shared types and constants for the hue wheel colour quantiser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hwq_pkg;

   localparam int CHAN_W          = 8;
   localparam int PSIZE_W         = 5;
   localparam int MIN_PALETTE     = 3;
   localparam int MAX_PALETTE_DEF = 30;
   localparam int PSIZE_RESET     = 3;
   localparam int DIST_W          = 18;
   localparam int SEG_W           = 3;
   localparam int DRAIN_CYCLES    = 4;

   localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;
   localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;

   // hue sectors
   localparam logic [SEG_W-1:0] SEG_RED_YEL = 3'd0;
   localparam logic [SEG_W-1:0] SEG_YEL_GRN = 3'd1;
   localparam logic [SEG_W-1:0] SEG_GRN_CYN = 3'd2;
   localparam logic [SEG_W-1:0] SEG_CYN_BLU = 3'd3;
   localparam logic [SEG_W-1:0] SEG_BLU_MAG = 3'd4;

   typedef struct packed {
      logic start;
      logic step;
      logic finish;
   } hwq_cmd_type;

   typedef struct packed {
      logic last_cand;
      logic out_busy;
   } hwq_status_type;

endpackage

`default_nettype wire

// ===== rtl/hwq_req_if.sv =====
// ---------------------------------------------------------------------------
// hwq_req_if
// Pixel request channel: valid/ready with one RGB pixel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hwq_req_if import hwq_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/hwq_rsp_if.sv =====
// ---------------------------------------------------------------------------
// hwq_rsp_if
// Result channel: valid/ready with the quantised RGB colour.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hwq_rsp_if import hwq_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_out;
   logic [CHAN_W-1:0] green_out;
   logic [CHAN_W-1:0] blue_out;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/hwq_ctrl.sv =====
// ---------------------------------------------------------------------------
// hwq_ctrl
// Sequencer: accepts a pixel, issues one candidate per cycle, drains the
// datapath pipeline and hands the winner to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hwq_ctrl import hwq_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire hwq_status_type status,
   output hwq_cmd_type         cmd
);

   localparam int DC_W = (DRAIN_CYCLES > 1) ? $clog2(DRAIN_CYCLES) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_HOLD  = 2'd3;

   logic [1:0]      state_ff, state_in;
   logic [DC_W-1:0] drain_ff, drain_in;

   always_comb begin
      state_in   = state_ff;
      drain_in   = drain_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_RUN;
            end
         end
         S_RUN: begin
            cmd.step = 1'b1;
            if (status.last_cand) begin
               drain_in = DC_W'(DRAIN_CYCLES - 1);
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (drain_ff == '0) begin
               state_in = S_HOLD;
            end else begin
               drain_in = drain_ff - 1'b1;
            end
         end
         S_HOLD: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         drain_ff <= drain_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/hwq_dpath.sv =====
// ---------------------------------------------------------------------------
// hwq_dpath
// Candidate generator, distance pipeline, best tracker and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hwq_dpath import hwq_pkg::*; #(
   parameter int MAX_PALETTE = MAX_PALETTE_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [PSIZE_W-1:0] csr_wr_data,
   input  wire logic [CHAN_W-1:0]  pix_red,
   input  wire logic [CHAN_W-1:0]  pix_green,
   input  wire logic [CHAN_W-1:0]  pix_blue,
   input  wire hwq_cmd_type        cmd,
   output hwq_status_type          status,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [CHAN_W-1:0]       rsp_red,
   output logic [CHAN_W-1:0]       rsp_green,
   output logic [CHAN_W-1:0]       rsp_blue
);

   localparam int NW     = $clog2(MAX_PALETTE + 1);
   localparam int CW     = (NW > PSIZE_W) ? NW : PSIZE_W;
   localparam int SUM_W  = NW + 3;
   localparam int NUM_W  = NW + CHAN_W;
   localparam int K      = 2 * NW + CHAN_W;
   localparam int PROD_W = NUM_W + K;
   localparam int SQ_W   = 2 * CHAN_W;

   // reciprocal table: ceil(2^K / n), exact floor for numerators below 2^NUM_W
   logic [K-1:0] recip_tbl [2**NW];
   for (genvar g = 0; g < 2**NW; g++) begin : g_recip
      localparam longint RV = ((longint'(1) << K) + g - 1) / ((g == 0) ? 1 : g);
      assign recip_tbl[g] = K'(RV);
   end

   // configuration
   logic [PSIZE_W-1:0] csr_ff;
   logic [CW-1:0]      ps_ext;
   logic [NW-1:0]      n_sel;

   always_comb begin
      ps_ext = CW'(csr_ff);
      if (ps_ext < CW'(MIN_PALETTE)) begin
         n_sel = NW'(MIN_PALETTE);
      end else if (ps_ext > CW'(MAX_PALETTE)) begin
         n_sel = NW'(MAX_PALETTE);
      end else begin
         n_sel = NW'(ps_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= PSIZE_W'(PSIZE_RESET);
      end else if (csr_wr_en) begin
         csr_ff <= csr_wr_data;
      end
   end

   // per-item registers
   logic [NW-1:0]     n_ff;
   logic [K-1:0]      recip_ff;
   logic [CHAN_W-1:0] pr_ff, pg_ff, pb_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         n_ff     <= n_sel;
         recip_ff <= recip_tbl[n_sel];
         pr_ff    <= pix_red;
         pg_ff    <= pix_green;
         pb_ff    <= pix_blue;
      end
   end

   // candidate generator: 6i = seg*n + rem
   logic [NW-1:0]    cnt_ff, rem_ff, rem_in;
   logic [SEG_W-1:0] seg_ff, seg_in;
   logic [SUM_W-1:0] sum0, sum1;

   always_comb begin
      sum0   = SUM_W'(rem_ff) + SUM_W'(6);
      seg_in = seg_ff;
      sum1   = sum0;
      if (sum0 >= SUM_W'(n_ff)) begin
         sum1   = sum0 - SUM_W'(n_ff);
         seg_in = seg_ff + 1'b1;
      end
      rem_in = NW'(sum1);
      if (sum1 >= SUM_W'(n_ff)) begin
         rem_in = NW'(sum1 - SUM_W'(n_ff));
         seg_in = seg_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cnt_ff <= '0;
         rem_ff <= '0;
         seg_ff <= '0;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff + 1'b1;
         rem_ff <= rem_in;
         seg_ff <= seg_in;
      end
   end

   assign status.last_cand = (cnt_ff == n_ff - 1'b1);

   // stage 1: numerator 255*rem
   logic             s1_v_ff;
   logic [NUM_W-1:0] s1_num_ff;
   logic [SEG_W-1:0] s1_seg_ff;

   always_ff @(posedge clock) begin
      s1_num_ff <= (NUM_W'(rem_ff) << CHAN_W) - NUM_W'(rem_ff);
      s1_seg_ff <= seg_ff;
   end

   // stage 2: frac by reciprocal multiply
   logic              s2_v_ff;
   logic [CHAN_W-1:0] s2_frac_ff;
   logic [SEG_W-1:0]  s2_seg_ff;
   logic [PROD_W-1:0] prod;

   assign prod = PROD_W'(s1_num_ff) * PROD_W'(recip_ff);

   always_ff @(posedge clock) begin
      s2_frac_ff <= prod[K +: CHAN_W];
      s2_seg_ff  <= s1_seg_ff;
   end

   // stage 3: sector colour and absolute differences
   logic              s3_v_ff;
   logic [CHAN_W-1:0] cr, cg, cb, inv;
   logic [CHAN_W-1:0] s3_r_ff, s3_g_ff, s3_b_ff;
   logic [CHAN_W-1:0] s3_dr_ff, s3_dg_ff, s3_db_ff;

   always_comb begin
      inv = CHAN_FULL - s2_frac_ff;
      case (s2_seg_ff)
         SEG_RED_YEL: begin cr = CHAN_FULL;  cg = s2_frac_ff; cb = CHAN_ZERO;  end
         SEG_YEL_GRN: begin cr = inv;        cg = CHAN_FULL;  cb = CHAN_ZERO;  end
         SEG_GRN_CYN: begin cr = CHAN_ZERO;  cg = CHAN_FULL;  cb = s2_frac_ff; end
         SEG_CYN_BLU: begin cr = CHAN_ZERO;  cg = inv;        cb = CHAN_FULL;  end
         SEG_BLU_MAG: begin cr = s2_frac_ff; cg = CHAN_ZERO;  cb = CHAN_FULL;  end
         default:     begin cr = CHAN_FULL;  cg = CHAN_ZERO;  cb = inv;        end
      endcase
   end

   always_ff @(posedge clock) begin
      s3_r_ff  <= cr;
      s3_g_ff  <= cg;
      s3_b_ff  <= cb;
      s3_dr_ff <= (cr > pr_ff) ? (cr - pr_ff) : (pr_ff - cr);
      s3_dg_ff <= (cg > pg_ff) ? (cg - pg_ff) : (pg_ff - cg);
      s3_db_ff <= (cb > pb_ff) ? (cb - pb_ff) : (pb_ff - cb);
   end

   // stage 4: squares
   logic              s4_v_ff;
   logic [CHAN_W-1:0] s4_r_ff, s4_g_ff, s4_b_ff;
   logic [SQ_W-1:0]   s4_sr_ff, s4_sg_ff, s4_sb_ff;

   always_ff @(posedge clock) begin
      s4_r_ff  <= s3_r_ff;
      s4_g_ff  <= s3_g_ff;
      s4_b_ff  <= s3_b_ff;
      s4_sr_ff <= SQ_W'(s3_dr_ff) * SQ_W'(s3_dr_ff);
      s4_sg_ff <= SQ_W'(s3_dg_ff) * SQ_W'(s3_dg_ff);
      s4_sb_ff <= SQ_W'(s3_db_ff) * SQ_W'(s3_db_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.step;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   // stage 5: running minimum, strict compare keeps the lower index on a tie
   logic [DIST_W-1:0] cand_dist, best_ff;
   logic [CHAN_W-1:0] br_ff, bg_ff, bb_ff;

   assign cand_dist = DIST_W'(s4_sr_ff) + DIST_W'(s4_sg_ff) + DIST_W'(s4_sb_ff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         best_ff <= '1;
      end else if (s4_v_ff && (cand_dist < best_ff)) begin
         best_ff <= cand_dist;
         br_ff   <= s4_r_ff;
         bg_ff   <= s4_g_ff;
         bb_ff   <= s4_b_ff;
      end
   end

   // output register
   logic              rsp_valid_ff;
   logic [CHAN_W-1:0] rsp_r_ff, rsp_g_ff, rsp_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_r_ff <= br_ff;
         rsp_g_ff <= bg_ff;
         rsp_b_ff <= bb_ff;
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red         = rsp_r_ff;
   assign rsp_green       = rsp_g_ff;
   assign rsp_blue        = rsp_b_ff;

endmodule

`default_nettype wire

// ===== rtl/hue_wheel_color_quantizer_unit.sv =====
// ---------------------------------------------------------------------------
// hue_wheel_color_quantizer_unit
// Maps an RGB pixel to the nearest of N evenly spaced saturated hues.
// ---------------------------------------------------------------------------
// req_port carries one pixel per transfer; rsp_port returns the nearest
// palette colour, one result per pixel, in order. csr_wr_en/csr_wr_data set
// the palette size N (values below 3 act as 3, above MAX_PALETTE as
// MAX_PALETTE); write it only while the unit is idle.
// After a pixel transfer one candidate hue enters the distance pipeline
// per cycle, the pipeline drains and the winner moves to the output
// register: the result becomes valid there in the same cycle in which
// req_port.ready rises again for the next pixel.
// Reset sets N to 3 and empties the output register.
// The output register holds a waiting result while a new pixel is taken;
// if the receiver still stalls when the next result is ready, the unit
// waits and holds req_port.ready low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hue_wheel_color_quantizer_unit import hwq_pkg::*; #(
   parameter int MAX_PALETTE = MAX_PALETTE_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   hwq_req_if.sink                 req_port,
   hwq_rsp_if.source               rsp_port,
   input  wire logic               csr_wr_en,
   input  wire logic [PSIZE_W-1:0] csr_wr_data
);

   hwq_cmd_type    cmd;
   hwq_status_type status;

   hwq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hwq_dpath #(
      .MAX_PALETTE (MAX_PALETTE)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pix_red     (req_port.red_in),
      .pix_green   (req_port.green_in),
      .pix_blue    (req_port.blue_in),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_port.valid),
      .rsp_ready   (rsp_port.ready),
      .rsp_red     (rsp_port.red_out),
      .rsp_green   (rsp_port.green_out),
      .rsp_blue    (rsp_port.blue_out)
   );

endmodule

`default_nettype wire

// ===== verif/hue_wheel_color_quantizer_unit_tb.sv =====
// ---------------------------------------------------------------------------
// hue_wheel_color_quantizer_unit_tb
// Self-checking bench: pixels go in over req_port, and each colour that
// comes back on rsp_port is checked against a nearest-hue search done here
// for the palette size in force. The palette size is stepped through a
// list of values from 0 to 31 between drained phases. The sender idles in
// bursts, the receiver stalls on its own pattern with two long hold-offs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hue_wheel_color_quantizer_unit_tb;
   import hwq_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_t;

   class hue_match_board;
      rgb_t               expected_q[$];
      logic [PSIZE_W-1:0] palette_reg = PSIZE_W'(PSIZE_RESET);
      int                 errors      = 0;

      function int active_size();
         if (palette_reg < MIN_PALETTE) return MIN_PALETTE;
         if (palette_reg > MAX_PALETTE_DEF) return MAX_PALETTE_DEF;
         return palette_reg;
      endfunction

      function rgb_t hue_entry(int idx, int n);
         int   seg;
         int   frac;
         rgb_t c;
         seg  = (6 * idx) / n;
         frac = (255 * ((6 * idx) % n)) / n;
         case (SEG_W'(seg))
            SEG_RED_YEL: c = {CHAN_FULL, 8'(frac), CHAN_ZERO};
            SEG_YEL_GRN: c = {8'(255 - frac), CHAN_FULL, CHAN_ZERO};
            SEG_GRN_CYN: c = {CHAN_ZERO, CHAN_FULL, 8'(frac)};
            SEG_CYN_BLU: c = {CHAN_ZERO, 8'(255 - frac), CHAN_FULL};
            SEG_BLU_MAG: c = {8'(frac), CHAN_ZERO, CHAN_FULL};
            default:     c = {CHAN_FULL, CHAN_ZERO, 8'(255 - frac)};
         endcase
         return c;
      endfunction

      // strict less-than keeps the lowest index on a tie
      function rgb_t nearest_hue(rgb_t px);
         int   n;
         int   dr, dg, db, sq_dist, best;
         rgb_t c, win;
         n    = active_size();
         best = 32'h7FFF_FFFF;
         win  = '0;
         for (int i = 0; i < n; i++) begin
            c       = hue_entry(i, n);
            dr      = int'(c.red) - int'(px.red);
            dg      = int'(c.green) - int'(px.green);
            db      = int'(c.blue) - int'(px.blue);
            sq_dist = dr * dr + dg * dg + db * db;
            if (sq_dist < best) begin
               best = sq_dist;
               win  = c;
            end
         end
         return win;
      endfunction

      function void note_pixel(rgb_t px);
         expected_q.push_back(nearest_hue(px));
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("[%0t] colour error, %s: got %0d, expected %0d", $realtime, what, got, want);
         errors++;
      endtask

      task check_colour(rgb_t got);
         rgb_t want;
         if (expected_q.size() == 0) begin
            report_mismatch("transfer with nothing pending", got, 0);
            return;
         end
         want = expected_q.pop_front();
         if (got.red !== want.red) report_mismatch("red_out", got.red, want.red);
         if (got.green !== want.green) report_mismatch("green_out", got.green, want.green);
         if (got.blue !== want.blue) report_mismatch("blue_out", got.blue, want.blue);
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en;
   logic [PSIZE_W-1:0] csr_wr_data;
   logic               long_hold;
   hue_match_board     board;

   hwq_req_if req_if ();
   hwq_rsp_if rsp_if ();

   hue_wheel_color_quantizer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_if),
      .rsp_port    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   initial begin
      #1_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [CHAN_W-1:0] clamp_chan(int v);
      if (v < 0) return CHAN_ZERO;
      if (v > 255) return CHAN_FULL;
      return CHAN_W'(v);
   endfunction

   task automatic wait_drained();
      while (board.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_pixel(rgb_t px);
      req_if.valid    <= 1'b1;
      req_if.red_in   <= px.red;
      req_if.green_in <= px.green;
      req_if.blue_in  <= px.blue;
      do @(posedge clock); while (!req_if.ready);
      board.note_pixel(px);
   endtask

   task automatic rest_req(int cycles);
      if (cycles > 0) begin
         req_if.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // only called with req_port idle
   task automatic set_palette(logic [PSIZE_W-1:0] value);
      wait_drained();
      repeat (DRAIN_CYCLES + 4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en         <= 1'b0;
      board.palette_reg  = value;
   endtask

   task automatic send_corners();
      rgb_t corners[12];
      corners = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
                  24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h808000, 24'h01FE7F, 24'hAA55AA};
      foreach (corners[k]) send_pixel(corners[k]);
      req_if.valid <= 1'b0;
   endtask

   task automatic send_batch(int count, bit with_hold, bit pause_mid);
      int   n, burst, mode, a;
      rgb_t px, pa, pb;
      n     = board.active_size();
      burst = with_hold ? count : $urandom_range(1, 16);
      if (with_hold) long_hold <= 1'b1;
      for (int k = 0; k < count; k++) begin
         mode = $urandom_range(0, 9);
         a    = $urandom_range(0, n - 1);
         pa   = board.hue_entry(a, n);
         pb   = board.hue_entry((a + 1) % n, n);
         if (mode < 3) begin
            px = 24'($urandom);
         end else if (mode < 7) begin
            px.red   = clamp_chan(int'(pa.red) + $urandom_range(0, 12) - 6);
            px.green = clamp_chan(int'(pa.green) + $urandom_range(0, 12) - 6);
            px.blue  = clamp_chan(int'(pa.blue) + $urandom_range(0, 12) - 6);
         end else if (mode < 9) begin
            // halfway between neighbouring hues: ties and near-ties
            px.red   = clamp_chan((int'(pa.red) + int'(pb.red)) / 2 + $urandom_range(0, 2) - 1);
            px.green = clamp_chan((int'(pa.green) + int'(pb.green)) / 2 + $urandom_range(0, 2) - 1);
            px.blue  = clamp_chan((int'(pa.blue) + int'(pb.blue)) / 2 + $urandom_range(0, 2) - 1);
         end else begin
            px.red   = $urandom_range(0, 1) ? CHAN_FULL - 8'($urandom_range(0, 1))
                                            : 8'($urandom_range(0, 1));
            px.green = $urandom_range(0, 1) ? CHAN_FULL : CHAN_ZERO;
            px.blue  = $urandom_range(0, 1) ? CHAN_FULL : CHAN_ZERO;
         end
         send_pixel(px);
         burst--;
         if (k == count - 1) begin
         end else if (pause_mid && k == count / 2) begin
            req_if.valid <= 1'b0;
            wait_drained();
         end else if (burst == 0) begin
            burst = $urandom_range(1, 16);
            rest_req(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
         end
      end
      req_if.valid <= 1'b0;
   endtask

   // receiver: check transfers, drive ready on a pattern, honour long hold-offs
   initial begin
      int mode, span, hold_left;
      rsp_if.ready = 1'b0;
      mode         = 0;
      span         = 0;
      hold_left    = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready)
            board.check_colour({rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out});
         if (long_hold && hold_left == 0) begin
            hold_left = 150 + $urandom_range(0, 100);
            long_hold <= 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(10, 120);
            end
            span--;
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 9) < 7);
               2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= (span % 4 == 0);
            endcase
         end
      end
   end

   initial begin
      int size_plan[23];
      board           = new;
      req_if.valid    = 1'b0;
      req_if.red_in   = '0;
      req_if.green_in = '0;
      req_if.blue_in  = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      long_hold       = 1'b0;
      size_plan = '{30, 0, 31, 1, 2, 3, 29, 4, 5, 6, 7, 12, 17, 24, 11, 13, 8, 9, 10, 15, 20,
                    25, 27};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_corners();
      set_palette(5'd30);
      send_corners();

      foreach (size_plan[p]) begin
         set_palette(PSIZE_W'(size_plan[p]));
         send_batch(29, (p == 2 || p == 9), (p == 5));
      end
      repeat (5) begin
         set_palette(PSIZE_W'($urandom_range(0, 31)));
         send_batch(29, 1'b0, 1'b0);
      end

      wait_drained();
      repeat (DRAIN_CYCLES + 40) @(posedge clock);
      if (board.errors == 0 && board.expected_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/hwq_pkg.sv
rtl/hwq_req_if.sv
rtl/hwq_rsp_if.sv
rtl/hwq_ctrl.sv
rtl/hwq_dpath.sv
rtl/hue_wheel_color_quantizer_unit.sv
verif/hue_wheel_color_quantizer_unit_tb.sv
